[design/koch_curve_segment_generator_unit_macros.svh]
// assertion macros shared by the koch curve generator
`ifndef KOCH_CURVE_SEGMENT_GENERATOR_UNIT_MACROS_SVH
`define KOCH_CURVE_SEGMENT_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define KCSG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kcsg same-cycle check failed");

// next-cycle implication
`define KCSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kcsg next-cycle check failed");

`endif

[design/kcsg_pkg.sv]
`timescale 1ns / 1ps

package kcsg_pkg;

   localparam int LEVEL_BITS  = 2;
   localparam int NUM_POINTS  = 5;
   localparam int PIPE_STAGES = 4;

   localparam int FRAC_BITS = 16;
   localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;
   localparam int COS60_Q16 = 32768;
   localparam int SIN60_Q16 = 56756;

   typedef logic [LEVEL_BITS-1:0] level_type;

   localparam level_type DEPTH_RESET = 2'd2;
   localparam level_type LAST_CHILD  = 2'd3;

   typedef struct packed {
      logic      load_input;
      logic      load_child;
      logic      split_start;
      logic      shift;
      logic      emit;
      logic      last;
      level_type level;
   } kcsg_cmd_type;

   typedef struct packed {
      logic split_done;
      logic out_free;
   } kcsg_status_type;

endpackage

[design/koch_curve_segment_generator_unit.sv]
`timescale 1ns / 1ps
// channel   handshake              payload
// request   req_valid / req_ready  req_start_x, req_start_y, req_end_x, req_end_y
// response  rsp_valid / rsp_ready  rsp_seg_from_x/y, rsp_seg_to_x/y, rsp_last_segment
// csr       csr_wr_en              csr_wr_data (depth)
//
// each request gives 4^(d+1) segments, d the depth capped at MAX_DEPTH; every
// split runs once through the shared four-stage divide and rotate pipeline,
// and the walk spends a state of its own on each descent, ascent and emitted
// segment
// one request at a time; req_ready is high only while idle
// a stalled response holds the walk, the result register keeps one segment
// reset is synchronous and active high, depth resets to 2

module koch_curve_segment_generator_unit #(
   parameter int MAX_DEPTH  = 2,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_seg_from_x,
   output logic signed [COORD_BITS-1:0]  rsp_seg_from_y,
   output logic signed [COORD_BITS-1:0]  rsp_seg_to_x,
   output logic signed [COORD_BITS-1:0]  rsp_seg_to_y,
   output logic                          rsp_last_segment,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_wr_data
);
   import kcsg_pkg::*;

   kcsg_cmd_type    cmd;
   kcsg_status_type status;

   kcsg_ctrl #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

   kcsg_dpath #(
      .MAX_DEPTH  (MAX_DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_seg_from_x   (rsp_seg_from_x),
      .rsp_seg_from_y   (rsp_seg_from_y),
      .rsp_seg_to_x     (rsp_seg_to_x),
      .rsp_seg_to_y     (rsp_seg_to_y),
      .rsp_last_segment (rsp_last_segment)
   );

endmodule

[design/kcsg_dpath.sv]
`timescale 1ns / 1ps

module kcsg_dpath #(
   parameter int MAX_DEPTH  = 2,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  kcsg_pkg::kcsg_cmd_type        cmd,
   output kcsg_pkg::kcsg_status_type     status,
   input  logic signed [COORD_BITS-1:0]  req_start_x,
   input  logic signed [COORD_BITS-1:0]  req_start_y,
   input  logic signed [COORD_BITS-1:0]  req_end_x,
   input  logic signed [COORD_BITS-1:0]  req_end_y,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [COORD_BITS-1:0]  rsp_seg_from_x,
   output logic signed [COORD_BITS-1:0]  rsp_seg_from_y,
   output logic signed [COORD_BITS-1:0]  rsp_seg_to_x,
   output logic signed [COORD_BITS-1:0]  rsp_seg_to_y,
   output logic                          rsp_last_segment
);
   import kcsg_pkg::*;

   localparam int NumLevels  = MAX_DEPTH + 1;
   localparam int RecipShift = COORD_BITS + 3;
   localparam int RecipBits  = RecipShift - 1;
   localparam int Recip      = ((1 << RecipShift) + 2) / 3;
   localparam int ProdBits   = COORD_BITS + 1 + RecipBits;
   localparam int MulBits    = COORD_BITS + 18;
   localparam int SumBits    = COORD_BITS + 20;

   localparam logic [RecipBits-1:0]      RecipV = RecipBits'(Recip);
   localparam logic signed [MulBits-1:0] SinW   = MulBits'(SIN60_Q16);
   localparam logic signed [SumBits-1:0] CosW   = SumBits'(COS60_Q16);
   localparam logic signed [SumBits-1:0] RndW   = SumBits'(FRAC_MASK);
   localparam logic signed [SumBits-1:0] SatHi  = SumBits'((1 << (COORD_BITS - 1)) - 1);
   localparam logic signed [SumBits-1:0] SatLo  = -SatHi - SumBits'(1);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [COORD_BITS:0]   wide_type;

   function automatic coord_type sat_coord(input logic signed [SumBits-1:0] v);
      coord_type r;
      if (v > SatHi) begin
         r = SatHi[COORD_BITS-1:0];
      end else if (v < SatLo) begin
         r = SatLo[COORD_BITS-1:0];
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   // segment being split
   coord_type seg_x0_ff, seg_y0_ff, seg_x1_ff, seg_y1_ff;

   // split points per level: start, one third, apex, two thirds, end
   coord_type pt_x_ff [NumLevels][NUM_POINTS];
   coord_type pt_y_ff [NumLevels][NUM_POINTS];

   logic [PIPE_STAGES-1:0] v_ff;
   logic                   done_ff;

   // stage 1
   wide_type                dx, dy;
   logic [COORD_BITS:0]     dx_abs, dy_abs;
   logic [COORD_BITS-1:0]   s1_mag_x_ff, s1_mag_y_ff;
   logic                    s1_neg_x_ff, s1_neg_y_ff;

   // stage 2
   logic [ProdBits-1:0]     pr1_x, pr2_x, pr1_y, pr2_y;
   logic [COORD_BITS-1:0]   s2_q1_x_ff, s2_q2_x_ff, s2_q1_y_ff, s2_q2_y_ff;
   logic                    s2_neg_x_ff, s2_neg_y_ff;

   // stage 3
   wide_type                e1_x, e2_x, e1_y, e2_y;
   wide_type                off1_x, off2_x, off1_y, off2_y;
   wide_type                p_full_x, q_full_x, p_full_y, q_full_y;
   wide_type                dm_x, dm_y;
   coord_type               s3_p_x_ff, s3_q_x_ff, s3_p_y_ff, s3_q_y_ff;
   wide_type                s3_m_x_ff, s3_m_y_ff;

   // stage 4
   logic signed [MulBits-1:0] ps_x, ps_y;
   logic signed [MulBits-1:0] s4_ps_x_ff, s4_ps_y_ff;
   coord_type                 s4_p_x_ff, s4_q_x_ff, s4_p_y_ff, s4_q_y_ff;
   wide_type                  s4_m_x_ff, s4_m_y_ff;

   // apex
   logic signed [SumBits-1:0] sum_x, sum_y, adj_x, adj_y, sh_x, sh_y;
   coord_type                 apex_x, apex_y;

   // result register
   logic      rsp_valid_ff;
   coord_type out_from_x_ff, out_from_y_ff, out_to_x_ff, out_to_y_ff;
   logic      out_last_ff;

   always_comb begin
      dx     = {seg_x1_ff[COORD_BITS-1], seg_x1_ff} - {seg_x0_ff[COORD_BITS-1], seg_x0_ff};
      dy     = {seg_y1_ff[COORD_BITS-1], seg_y1_ff} - {seg_y0_ff[COORD_BITS-1], seg_y0_ff};
      dx_abs = dx[COORD_BITS] ? -dx : dx;
      dy_abs = dy[COORD_BITS] ? -dy : dy;

      // divide by three through the reciprocal
      pr1_x = ProdBits'(s1_mag_x_ff) * ProdBits'(RecipV);
      pr2_x = ProdBits'({s1_mag_x_ff, 1'b0}) * ProdBits'(RecipV);
      pr1_y = ProdBits'(s1_mag_y_ff) * ProdBits'(RecipV);
      pr2_y = ProdBits'({s1_mag_y_ff, 1'b0}) * ProdBits'(RecipV);

      e1_x     = {1'b0, s2_q1_x_ff};
      e2_x     = {1'b0, s2_q2_x_ff};
      e1_y     = {1'b0, s2_q1_y_ff};
      e2_y     = {1'b0, s2_q2_y_ff};
      off1_x   = s2_neg_x_ff ? -e1_x : e1_x;
      off2_x   = s2_neg_x_ff ? -e2_x : e2_x;
      off1_y   = s2_neg_y_ff ? -e1_y : e1_y;
      off2_y   = s2_neg_y_ff ? -e2_y : e2_y;
      p_full_x = {seg_x0_ff[COORD_BITS-1], seg_x0_ff} + off1_x;
      q_full_x = {seg_x0_ff[COORD_BITS-1], seg_x0_ff} + off2_x;
      p_full_y = {seg_y0_ff[COORD_BITS-1], seg_y0_ff} + off1_y;
      q_full_y = {seg_y0_ff[COORD_BITS-1], seg_y0_ff} + off2_y;
      dm_x     = e2_x - e1_x;
      dm_y     = e2_y - e1_y;

      ps_x = MulBits'(s3_m_x_ff) * SinW;
      ps_y = MulBits'(s3_m_y_ff) * SinW;

      // rotate the middle third by sixty degrees, y downward
      sum_x  = (SumBits'(s4_p_x_ff) <<< FRAC_BITS) + SumBits'(s4_m_x_ff) * CosW
             + SumBits'(s4_ps_y_ff);
      sum_y  = (SumBits'(s4_p_y_ff) <<< FRAC_BITS) - SumBits'(s4_ps_x_ff)
             + SumBits'(s4_m_y_ff) * CosW;
      adj_x  = sum_x + (sum_x[SumBits-1] ? RndW : '0);
      adj_y  = sum_y + (sum_y[SumBits-1] ? RndW : '0);
      sh_x   = adj_x >>> FRAC_BITS;
      sh_y   = adj_y >>> FRAC_BITS;
      apex_x = sat_coord(sh_x);
      apex_y = sat_coord(sh_y);
   end

   always_ff @(posedge clock) begin
      s1_mag_x_ff <= dx_abs[COORD_BITS-1:0];
      s1_mag_y_ff <= dy_abs[COORD_BITS-1:0];
      s1_neg_x_ff <= dx[COORD_BITS];
      s1_neg_y_ff <= dy[COORD_BITS];

      s2_q1_x_ff  <= pr1_x[RecipShift +: COORD_BITS];
      s2_q2_x_ff  <= pr2_x[RecipShift +: COORD_BITS];
      s2_q1_y_ff  <= pr1_y[RecipShift +: COORD_BITS];
      s2_q2_y_ff  <= pr2_y[RecipShift +: COORD_BITS];
      s2_neg_x_ff <= s1_neg_x_ff;
      s2_neg_y_ff <= s1_neg_y_ff;

      s3_p_x_ff <= p_full_x[COORD_BITS-1:0];
      s3_q_x_ff <= q_full_x[COORD_BITS-1:0];
      s3_p_y_ff <= p_full_y[COORD_BITS-1:0];
      s3_q_y_ff <= q_full_y[COORD_BITS-1:0];
      s3_m_x_ff <= s2_neg_x_ff ? -dm_x : dm_x;
      s3_m_y_ff <= s2_neg_y_ff ? -dm_y : dm_y;

      s4_ps_x_ff <= ps_x;
      s4_ps_y_ff <= ps_y;
      s4_p_x_ff  <= s3_p_x_ff;
      s4_q_x_ff  <= s3_q_x_ff;
      s4_p_y_ff  <= s3_p_y_ff;
      s4_q_y_ff  <= s3_q_y_ff;
      s4_m_x_ff  <= s3_m_x_ff;
      s4_m_y_ff  <= s3_m_y_ff;

      if (cmd.load_input) begin
         seg_x0_ff <= req_start_x;
         seg_y0_ff <= req_start_y;
         seg_x1_ff <= req_end_x;
         seg_y1_ff <= req_end_y;
      end else if (cmd.load_child) begin
         seg_x0_ff <= pt_x_ff[cmd.level][0];
         seg_y0_ff <= pt_y_ff[cmd.level][0];
         seg_x1_ff <= pt_x_ff[cmd.level][1];
         seg_y1_ff <= pt_y_ff[cmd.level][1];
      end

      if (v_ff[PIPE_STAGES-1]) begin
         pt_x_ff[cmd.level][0] <= seg_x0_ff;
         pt_y_ff[cmd.level][0] <= seg_y0_ff;
         pt_x_ff[cmd.level][1] <= s4_p_x_ff;
         pt_y_ff[cmd.level][1] <= s4_p_y_ff;
         pt_x_ff[cmd.level][2] <= apex_x;
         pt_y_ff[cmd.level][2] <= apex_y;
         pt_x_ff[cmd.level][3] <= s4_q_x_ff;
         pt_y_ff[cmd.level][3] <= s4_q_y_ff;
         pt_x_ff[cmd.level][4] <= seg_x1_ff;
         pt_y_ff[cmd.level][4] <= seg_y1_ff;
      end else if (cmd.shift) begin
         for (int k = 0; k < NUM_POINTS - 1; k++) begin
            pt_x_ff[cmd.level][k] <= pt_x_ff[cmd.level][k+1];
            pt_y_ff[cmd.level][k] <= pt_y_ff[cmd.level][k+1];
         end
      end

      if (cmd.emit) begin
         out_from_x_ff <= pt_x_ff[cmd.level][0];
         out_from_y_ff <= pt_y_ff[cmd.level][0];
         out_to_x_ff   <= pt_x_ff[cmd.level][1];
         out_to_y_ff   <= pt_y_ff[cmd.level][1];
         out_last_ff   <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff    <= {v_ff[PIPE_STAGES-2:0], cmd.split_start};
         done_ff <= v_ff[PIPE_STAGES-1];
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.split_done = done_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seg_from_x   = out_from_x_ff;
   assign rsp_seg_from_y   = out_from_y_ff;
   assign rsp_seg_to_x     = out_to_x_ff;
   assign rsp_seg_to_y     = out_to_y_ff;
   assign rsp_last_segment = out_last_ff;

endmodule

[design/kcsg_ctrl.sv]
`timescale 1ns / 1ps
`include "koch_curve_segment_generator_unit_macros.svh"

module kcsg_ctrl #(
   parameter int MAX_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       csr_wr_en,
   input  kcsg_pkg::level_type        csr_wr_data,
   output kcsg_pkg::kcsg_cmd_type     cmd,
   input  kcsg_pkg::kcsg_status_type  status
);
   import kcsg_pkg::*;

   localparam int NumLevels = MAX_DEPTH + 1;
   localparam level_type MaxLevel = LEVEL_BITS'(MAX_DEPTH);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_START   = 3'd1;
   localparam logic [2:0] ST_WAIT    = 3'd2;
   localparam logic [2:0] ST_EMIT    = 3'd3;
   localparam logic [2:0] ST_ASCEND  = 3'd4;
   localparam logic [2:0] ST_DESCEND = 3'd5;

   logic [2:0] state_ff, state_in;
   level_type  sp_ff, sp_in;
   level_type  lv_ff, lv_in;
   level_type  depth_ff;
   level_type  cnt_ff [NumLevels];
   level_type  cnt_in [NumLevels];
   level_type  eff_depth;
   level_type  parent;
   logic       last_seg;

   always_comb begin
      eff_depth = (depth_ff > MaxLevel) ? MaxLevel : depth_ff;
      parent    = sp_ff - 1'b1;

      // final segment when every open level sits on its last child
      last_seg = 1'b1;
      for (int j = 0; j < NumLevels; j++) begin
         if (LEVEL_BITS'(j) <= sp_ff && cnt_ff[j] != LAST_CHILD) begin
            last_seg = 1'b0;
         end
      end

      state_in  = state_ff;
      sp_in     = sp_ff;
      lv_in     = lv_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.level = sp_ff;
      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_input = 1'b1;
               sp_in          = '0;
               lv_in          = eff_depth;
               state_in       = ST_START;
            end
         end
         ST_START: begin
            cmd.split_start = 1'b1;
            state_in        = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.split_done) begin
               cnt_in[sp_ff] = '0;
               state_in      = (sp_ff == lv_ff) ? ST_EMIT : ST_DESCEND;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.shift     = 1'b1;
               cmd.last      = last_seg;
               cnt_in[sp_ff] = cnt_ff[sp_ff] + 1'b1;
               if (cnt_ff[sp_ff] == LAST_CHILD) begin
                  state_in = ST_ASCEND;
               end
            end
         end
         ST_ASCEND: begin
            if (sp_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cmd.level = parent;
               sp_in     = parent;
               if (cnt_ff[parent] != LAST_CHILD) begin
                  cmd.shift      = 1'b1;
                  cnt_in[parent] = cnt_ff[parent] + 1'b1;
                  state_in       = ST_DESCEND;
               end
            end
         end
         ST_DESCEND: begin
            cmd.load_child = 1'b1;
            sp_in          = sp_ff + 1'b1;
            state_in       = ST_START;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         lv_ff    <= '0;
         depth_ff <= DEPTH_RESET;
         for (int j = 0; j < NumLevels; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         lv_ff    <= lv_in;
         cnt_ff   <= cnt_in;
         if (csr_wr_en) begin
            depth_ff <= csr_wr_data;
         end
      end
   end

   `KCSG_ASSERT_NOW(a_level_bound, clock, reset, state_ff != ST_IDLE, sp_ff <= lv_ff)
   `KCSG_ASSERT_NOW(a_done_in_wait, clock, reset, status.split_done, state_ff == ST_WAIT)
   `KCSG_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready,
                     state_ff == ST_START && sp_ff == '0)
   `KCSG_ASSERT_NEXT(a_inner_descends, clock, reset,
                     state_ff == ST_WAIT && status.split_done && sp_ff != lv_ff,
                     state_ff == ST_DESCEND)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import kcsg_pkg::*;

   localparam int  DEPTH_CAP      = 2;
   localparam int  STALL_PERCENT  = 32;
   localparam int  WATCHDOG_LIMIT = 5000;
   localparam int  DRAIN_CYCLES   = 250;
   localparam int  PHASE_ITEMS    = 39;
   localparam longint COS60_FIX   = 32768;
   localparam longint SIN60_FIX   = 56756;

   typedef struct {
      logic signed [15:0] from_x;
      logic signed [15:0] from_y;
      logic signed [15:0] to_x;
      logic signed [15:0] to_y;
      logic               last_flag;
   } curve_seg_t;

   class koch_scoreboard;
      level_type  depth_reg;
      curve_seg_t curve_q[$];
      int         mismatches;

      function new();
         depth_reg  = DEPTH_RESET;
         mismatches = 0;
      endfunction

      function int pending();
         return curve_q.size();
      endfunction

      function longint clamp_coord(longint v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      function void push_piece(longint ax, longint ay, longint bx, longint by);
         curve_seg_t s;
         s.from_x    = ax[15:0];
         s.from_y    = ay[15:0];
         s.to_x      = bx[15:0];
         s.to_y      = by[15:0];
         s.last_flag = 1'b0;
         curve_q.push_back(s);
      endfunction

      function void split_segment(longint x0, longint y0, longint x1, longint y1,
                                  int level);
         longint dx, dy, px, py, qx, qy, mx, my, ax, ay;
         dx = x1 - x0;
         dy = y1 - y0;
         px = x0 + dx / 3;
         py = y0 + dy / 3;
         qx = x0 + (2 * dx) / 3;
         qy = y0 + (2 * dy) / 3;
         mx = qx - px;
         my = qy - py;
         ax = clamp_coord((px * 65536 + mx * COS60_FIX + my * SIN60_FIX) / 65536);
         ay = clamp_coord((py * 65536 - mx * SIN60_FIX + my * COS60_FIX) / 65536);
         if (level > 0) begin
            split_segment(x0, y0, px, py, level - 1);
            split_segment(px, py, ax, ay, level - 1);
            split_segment(ax, ay, qx, qy, level - 1);
            split_segment(qx, qy, x1, y1, level - 1);
         end else begin
            push_piece(x0, y0, px, py);
            push_piece(px, py, ax, ay);
            push_piece(ax, ay, qx, qy);
            push_piece(qx, qy, x1, y1);
         end
      endfunction

      function void note_request(logic signed [15:0] sx, logic signed [15:0] sy,
                                 logic signed [15:0] ex, logic signed [15:0] ey);
         int lv;
         lv = (depth_reg > DEPTH_CAP) ? DEPTH_CAP : int'(depth_reg);
         split_segment(longint'(sx), longint'(sy), longint'(ex), longint'(ey), lv);
         curve_q[curve_q.size() - 1].last_flag = 1'b1;
      endfunction

      function void check_segment(logic signed [15:0] fx, logic signed [15:0] fy,
                                  logic signed [15:0] tx, logic signed [15:0] ty,
                                  logic lf);
         curve_seg_t e;
         if (curve_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected segment %0d,%0d -> %0d,%0d last %0b",
                        fx, fy, tx, ty, lf);
            return;
         end
         e = curve_q.pop_front();
         if (e.from_x !== fx || e.from_y !== fy || e.to_x !== tx || e.to_y !== ty ||
             e.last_flag !== lf) begin
            mismatches++;
            if (mismatches <= 10)
               $display("segment mismatch: expected %0d,%0d -> %0d,%0d last %0b, got %0d,%0d -> %0d,%0d last %0b",
                        e.from_x, e.from_y, e.to_x, e.to_y, e.last_flag,
                        fx, fy, tx, ty, lf);
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_start_x = '0;
   logic signed [15:0] req_start_y = '0;
   logic signed [15:0] req_end_x = '0;
   logic signed [15:0] req_end_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_seg_from_x;
   logic signed [15:0] rsp_seg_from_y;
   logic signed [15:0] rsp_seg_to_x;
   logic signed [15:0] rsp_seg_to_y;
   logic               rsp_last_segment;
   logic               csr_wr_en = 1'b0;
   level_type          csr_wr_data = '0;

   koch_scoreboard board;
   logic           no_idle = 1'b0;
   int             quiet_cycles = 0;

   int directed_segs[12][4] = '{
      '{-32768, -32768,  32767,  32767},
      '{ 32767,  32767, -32768, -32768},
      '{-32768,  32767,  32767, -32768},
      '{     0,      0,      0,      0},
      '{ 12345,  -2222,  12345,  -2222},
      '{-32768, -32768,  32767, -32768},
      '{ 32767,  32767, -32768,  32767},
      '{ 32767, -32768,  32767,  32767},
      '{-32768,  32767, -32768, -32768},
      '{     1,      2,      4,      5},
      '{    -1,     -1,      1,      1},
      '{     3,      0,      0,      0}
   };

   koch_curve_segment_generator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_seg_from_x   (rsp_seg_from_x),
      .rsp_seg_from_y   (rsp_seg_from_y),
      .rsp_seg_to_x     (rsp_seg_to_x),
      .rsp_seg_to_y     (rsp_seg_to_y),
      .rsp_last_segment (rsp_last_segment),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(0, 99) >= STALL_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_segment(rsp_seg_from_x, rsp_seg_from_y, rsp_seg_to_x,
                             rsp_seg_to_y, rsp_last_segment);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   function automatic int rand_coord();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   function automatic int border_coord();
      case ($urandom_range(0, 4))
         0: return -32768;
         1: return 32767;
         2: return -32767;
         3: return 32766;
         default: return rand_coord();
      endcase
   endfunction

   task automatic send_segment(int sx, int sy, int ex, int ey);
      int gap;
      gap = 0;
      while (!no_idle && $urandom_range(0, 99) < STALL_PERCENT)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_start_x <= sx[15:0];
      req_start_y <= sy[15:0];
      req_end_x   <= ex[15:0];
      req_end_y   <= ey[15:0];
      do @(posedge clock); while (!req_ready);
      board.note_request(sx[15:0], sy[15:0], ex[15:0], ey[15:0]);
   endtask

   task automatic drain_curves();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_depth(level_type d);
      drain_curves();
      while (!req_ready) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.depth_reg = d;
   endtask

   task automatic send_directed(int first, int last_idx);
      for (int i = first; i <= last_idx; i++)
         send_segment(directed_segs[i][0], directed_segs[i][1],
                      directed_segs[i][2], directed_segs[i][3]);
   endtask

   task automatic send_random_segment();
      int kind, cx, cy, sx, sy;
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
         send_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else if (kind < 70) begin
         cx = $urandom_range(0, 60000) - 30000;
         cy = $urandom_range(0, 60000) - 30000;
         send_segment(cx + $urandom_range(0, 600) - 300, cy + $urandom_range(0, 600) - 300,
                      cx + $urandom_range(0, 600) - 300, cy + $urandom_range(0, 600) - 300);
      end else if (kind < 80) begin
         sx = rand_coord();
         sy = rand_coord();
         send_segment(sx, sy, sx, sy);
      end else if (kind < 90) begin
         send_segment(border_coord(), border_coord(), border_coord(), border_coord());
      end else begin
         sx = rand_coord();
         sy = rand_coord();
         if ($urandom_range(0, 1))
            send_segment(sx, sy, rand_coord(), sy);
         else
            send_segment(sx, sy, sx, rand_coord());
      end
   endtask

   level_type phase_depths[10] = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd1,
                                    2'd0, 2'd3};

   initial begin
      board = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset depth, then the capped depth, then the shallowest
      send_directed(0, 11);
      write_depth(2'd3);
      send_directed(3, 8);
      write_depth(2'd0);
      send_directed(0, 6);

      for (int p = 0; p < 10; p++) begin
         write_depth(phase_depths[p]);
         no_idle = (p == 4);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 1 && i == 20)
               drain_curves();
            send_random_segment();
         end
      end
      no_idle = 1'b0;

      drain_curves();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
